[rtl/pdws_pkg.sv]
// ----------------------------------------------------------------------------
// pdws_pkg
// Shared types and constants for the differential wheel speed PID block:
// register map, reset values, datapath command and status bundles.
// ----------------------------------------------------------------------------
package pdws_pkg;

    // port widths
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 56;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 18;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = 43;

    // integral is multiplied in chunks of this many bits, top chunk first
    localparam int CHUNK_W = 24;

    // register map
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_P        = 3'd0,
        REG_GAIN_I        = 3'd1,
        REG_GAIN_D        = 3'd2,
        REG_SAMPLE_PERIOD = 3'd3,
        REG_SAMPLE_RATE   = 3'd4,
        REG_SPEED_LIMIT   = 3'd5
    } reg_index_t;

    // register reset values
    localparam logic [15:0] GAIN_P_RST        = 16'hFD00;   // -3.0 in Q8.8
    localparam logic [15:0] GAIN_I_RST        = 16'h0100;   // 1.0
    localparam logic [15:0] GAIN_D_RST        = 16'h0200;   // 2.0
    localparam logic [23:0] SAMPLE_PERIOD_RST = 24'd16777;  // about 1 ms in Q0.24
    localparam logic [15:0] SAMPLE_RATE_RST   = 16'd1000;
    localparam logic [14:0] SPEED_LIMIT_RST   = 15'd1638;   // about 0.4 in Q3.12

    // configuration register bank contents
    typedef struct packed {
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [23:0] sample_period;
        logic [15:0] sample_rate;
        logic [14:0] speed_limit;
    } cfg_t;

    // multiplier operand selection
    typedef enum logic [2:0] {
        MUL_INC = 3'd0,   // error x sample period
        MUL_P   = 3'd1,   // gain_p x error
        MUL_D0  = 3'd2,   // gain_d x error difference
        MUL_DHI = 3'd3,   // sample rate x upper part of derivative product
        MUL_DLO = 3'd4,   // sample rate x lower part of derivative product
        MUL_INT = 3'd5    // gain_i x current integral chunk
    } mul_sel_t;

    // accumulator operation
    typedef enum logic [1:0] {
        ACC_HOLD  = 2'd0,
        ACC_LOAD  = 2'd1,
        ACC_SHADD = 2'd2
    } acc_op_t;

    // controller to datapath commands
    typedef struct packed {
        logic     load;
        logic     diff_en;
        mul_sel_t mul_sel;
        logic     int_en;
        logic     p_en;
        logic     t_en;
        acc_op_t  acc_op;
        logic     pd_en;
        logic     chunk_init;
        logic     chunk_dec;
        logic     effort_en;
        logic     out_load;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic chunk_top;
        logic chunk_zero;
    } dp_status_t;

endpackage

[rtl/pdws_cfg.sv]
// ----------------------------------------------------------------------------
// pdws_cfg
// Configuration register bank: gains, sample period and rate, speed limit.
// ----------------------------------------------------------------------------
module pdws_cfg import pdws_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // writes are always accepted, cfg_ready is held high
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // decode register index, unknown indexes ignored
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_GAIN_P:        cfg_next.gain_p        = cfg_data[15:0];
                REG_GAIN_I:        cfg_next.gain_i        = cfg_data[15:0];
                REG_GAIN_D:        cfg_next.gain_d        = cfg_data[15:0];
                REG_SAMPLE_PERIOD: cfg_next.sample_period = cfg_data[23:0];
                REG_SAMPLE_RATE:   cfg_next.sample_rate   = cfg_data[15:0];
                REG_SPEED_LIMIT:   cfg_next.speed_limit   = cfg_data[14:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // register bank
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p        <= GAIN_P_RST;
            cfg_reg.gain_i        <= GAIN_I_RST;
            cfg_reg.gain_d        <= GAIN_D_RST;
            cfg_reg.sample_period <= SAMPLE_PERIOD_RST;
            cfg_reg.sample_rate   <= SAMPLE_RATE_RST;
            cfg_reg.speed_limit   <= SPEED_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/pdws_ctrl.sv]
// ----------------------------------------------------------------------------
// pdws_ctrl
// Sequencer for one sample: steps the shared multiplier through the
// integral, P, D and I terms and hands the result to the output register.
// ----------------------------------------------------------------------------
module pdws_ctrl import pdws_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_INT,
        ST_PD,
        ST_DT,
        ST_DHI,
        ST_DLO,
        ST_DACC,
        ST_PDSUM,
        ST_IMUL,
        ST_IACC,
        ST_EFF,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // command decode and next state
    always_comb begin
        cmd           = '0;
        cmd.mul_sel   = MUL_INC;
        cmd.acc_op    = ACC_HOLD;
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        case (state_reg)
            ST_IDLE: begin
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR: begin
                cmd.diff_en = 1'b1;
                cmd.mul_sel = MUL_INC;
                state_next  = ST_INT;
            end
            ST_INT: begin
                cmd.int_en  = 1'b1;
                cmd.mul_sel = MUL_P;
                state_next  = ST_PD;
            end
            ST_PD: begin
                cmd.p_en    = 1'b1;
                cmd.mul_sel = MUL_D0;
                state_next  = ST_DT;
            end
            ST_DT: begin
                cmd.t_en   = 1'b1;
                state_next = ST_DHI;
            end
            ST_DHI: begin
                cmd.mul_sel = MUL_DHI;
                state_next  = ST_DLO;
            end
            ST_DLO: begin
                cmd.acc_op  = ACC_LOAD;
                cmd.mul_sel = MUL_DLO;
                state_next  = ST_DACC;
            end
            ST_DACC: begin
                cmd.acc_op = ACC_SHADD;
                state_next = ST_PDSUM;
            end
            ST_PDSUM: begin
                cmd.pd_en      = 1'b1;
                cmd.chunk_init = 1'b1;
                state_next     = ST_IMUL;
            end
            ST_IMUL: begin
                cmd.mul_sel = MUL_INT;
                state_next  = ST_IACC;
            end
            ST_IACC: begin
                cmd.acc_op = status.chunk_top ? ACC_LOAD : ACC_SHADD;
                if (status.chunk_zero) begin
                    state_next = ST_EFF;
                end else begin
                    cmd.chunk_dec = 1'b1;
                    state_next    = ST_IMUL;
                end
            end
            ST_EFF: begin
                cmd.effort_en = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                // wait here while the previous result is still held
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten while held");

    // one sample at a time: no second request right after an accepted one
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a sample is in progress");

    // output valid only rises from a result load
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.out_load))
        else $error("output valid without a result load");

    // the integral chunk loop ends on the lowest chunk
    a_chunk_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EFF) |-> $past(status.chunk_zero))
        else $error("integral term finished before the lowest chunk");

endmodule

[rtl/pdws_datapath.sv]
// ----------------------------------------------------------------------------
// pdws_datapath
// Error, integral and PID term arithmetic around one shared 18 x 25 signed
// multiplier, effort saturation, wheel speed clamp and result register.
// ----------------------------------------------------------------------------
module pdws_datapath import pdws_pkg::*; #(
    parameter int INTEGRAL_WIDTH = 40
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int NCH   = (INTEGRAL_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int CW    = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int EXT_W = NCH * CHUNK_W;
    localparam int ACC_W = (INTEGRAL_WIDTH + 17 > 52) ? INTEGRAL_WIDTH + 17 : 52;
    localparam int SUM_W = ACC_W + 2;
    localparam int INC_W = 29;
    localparam int SAT_W = ((INTEGRAL_WIDTH > INC_W) ? INTEGRAL_WIDTH : INC_W) + 1;

    localparam logic signed [SAT_W-1:0] INT_HI =
        signed'({{(SAT_W-INTEGRAL_WIDTH+1){1'b0}}, {(INTEGRAL_WIDTH-1){1'b1}}});
    localparam logic signed [SAT_W-1:0] INT_LO = ~INT_HI;
    localparam logic signed [SUM_W-1:0] EFF_HI = signed'({{(SUM_W-23){1'b0}}, {23{1'b1}}});
    localparam logic signed [SUM_W-1:0] EFF_LO = ~EFF_HI;

    // sample state and intermediate terms
    logic signed [16:0]               err_reg;
    logic signed [16:0]               last_err_reg;
    logic signed [17:0]               diff_reg;
    logic signed [INTEGRAL_WIDTH-1:0] integral_reg;
    logic signed [INTEGRAL_WIDTH-1:0] integral_next;
    logic signed [24:0]               p_reg;
    logic signed [33:0]               t_reg;
    logic signed [ACC_W-1:0]          acc_reg;
    logic signed [ACC_W-1:0]          acc_next;
    logic signed [SUM_W-1:0]          sum_reg;
    logic signed [23:0]               effort_reg;
    logic signed [23:0]               effort_next;
    logic signed [MUL_P_W-1:0]        prod_reg;
    logic signed [MUL_P_W-1:0]        prod_next;
    logic [CW-1:0]                    chunk_reg;
    logic [14:0]                      left_reg;
    logic [14:0]                      right_reg;
    logic [23:0]                      out_effort_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [EXT_W-1:0]   int_ext;
    logic [CHUNK_W-1:0]        chunk;
    logic signed [INC_W-1:0]   inc;
    logic signed [SAT_W-1:0]   isum;
    logic signed [SUM_W-1:0]   total;
    logic signed [25:0]        maxs_ext;
    logic signed [25:0]        eff_ext;
    logic signed [25:0]        left_full;
    logic signed [25:0]        right_full;

    // clamp a speed to 0..limit
    function automatic logic [14:0] clamp_speed(input logic signed [25:0] v,
                                                input logic [14:0] limit);
        logic [14:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > signed'({11'b0, limit})) begin
            res = limit;
        end else begin
            res = v[14:0];
        end
        return res;
    endfunction

    // integral chunk, top chunk signed and the rest unsigned
    assign int_ext           = EXT_W'(integral_reg);
    assign chunk             = int_ext[chunk_reg*CHUNK_W +: CHUNK_W];
    assign status.chunk_top  = (chunk_reg == CW'(NCH - 1));
    assign status.chunk_zero = (chunk_reg == '0);

    // shared multiplier operand selection
    always_comb begin
        case (cmd.mul_sel)
            MUL_INC: begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = signed'({1'b0, cfg.sample_period});
            end
            MUL_P: begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = MUL_B_W'($signed(cfg.gain_p));
            end
            MUL_D0: begin
                mul_a = diff_reg;
                mul_b = MUL_B_W'($signed(cfg.gain_d));
            end
            MUL_DHI: begin
                mul_a = signed'({2'b0, cfg.sample_rate});
                mul_b = MUL_B_W'($signed(t_reg[33:24]));
            end
            MUL_DLO: begin
                mul_a = signed'({2'b0, cfg.sample_rate});
                mul_b = signed'({1'b0, t_reg[23:0]});
            end
            MUL_INT: begin
                mul_a = MUL_A_W'($signed(cfg.gain_i));
                mul_b = status.chunk_top ? MUL_B_W'($signed(chunk))
                                         : signed'({1'b0, chunk});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // saturating integral update, increment is error x period floored by 2^12
    always_comb begin
        inc  = prod_reg[40:12];
        isum = SAT_W'(integral_reg) + SAT_W'(inc);
        if (isum > INT_HI) begin
            integral_next = INTEGRAL_WIDTH'(INT_HI);
        end else if (isum < INT_LO) begin
            integral_next = INTEGRAL_WIDTH'(INT_LO);
        end else begin
            integral_next = INTEGRAL_WIDTH'(isum);
        end
    end

    // accumulator for multi-part products, highest part first
    always_comb begin
        case (cmd.acc_op)
            ACC_LOAD:  acc_next = ACC_W'(prod_reg);
            ACC_SHADD: acc_next = (acc_reg <<< CHUNK_W) + ACC_W'(prod_reg);
            default:   acc_next = acc_reg;
        endcase
    end

    // add integral term to p + d and saturate the effort
    always_comb begin
        total = sum_reg + SUM_W'($signed(acc_reg[ACC_W-1:20]));
        if (total > EFF_HI) begin
            effort_next = 24'(EFF_HI);
        end else if (total < EFF_LO) begin
            effort_next = 24'(EFF_LO);
        end else begin
            effort_next = 24'(total);
        end
    end

    // wheel speeds around the limit
    assign maxs_ext   = signed'({11'b0, cfg.speed_limit});
    assign eff_ext    = 26'(effort_reg);
    assign left_full  = maxs_ext - eff_ext;
    assign right_full = maxs_ext + eff_ext;

    // controller state kept across samples
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg <= '0;
            last_err_reg <= '0;
            chunk_reg    <= '0;
        end else begin
            if (cmd.int_en) begin
                integral_reg <= integral_next;
            end
            if (cmd.diff_en) begin
                last_err_reg <= err_reg;
            end
            if (cmd.chunk_init) begin
                chunk_reg <= CW'(NCH - 1);
            end else if (cmd.chunk_dec) begin
                chunk_reg <= chunk_reg - 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (cmd.load) begin
            err_reg <= 17'($signed(s_tdata[15:0])) - 17'($signed(s_tdata[31:16]));
        end
        if (cmd.diff_en) begin
            diff_reg <= 18'(last_err_reg) - 18'(err_reg);
        end
        if (cmd.p_en) begin
            p_reg <= prod_reg[32:8];
        end
        if (cmd.t_en) begin
            t_reg <= prod_reg[33:0];
        end
        if (cmd.pd_en) begin
            sum_reg <= SUM_W'(p_reg) + SUM_W'($signed(acc_reg[ACC_W-1:8]));
        end
        if (cmd.effort_en) begin
            effort_reg <= effort_next;
        end
        if (cmd.out_load) begin
            left_reg       <= clamp_speed(left_full, cfg.speed_limit);
            right_reg      <= clamp_speed(right_full, cfg.speed_limit);
            out_effort_reg <= effort_reg;
        end
    end

    assign m_tdata = {2'b00, out_effort_reg, right_reg, left_reg};

endmodule

[rtl/pid_differential_wheel_speed_top.sv]
// ----------------------------------------------------------------------------
// pid_differential_wheel_speed_top
// One shared 18 x 25 multiplier computes every term, and the integral term is
// multiplied in 24-bit chunks, top chunk first. A new sample is taken only once
// the previous result has been loaded into the output register.
// Reset (aresetn, synchronous, active low) clears integral and previous error
// and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pid_differential_wheel_speed_top import pdws_pkg::*; #(
    parameter int INTEGRAL_WIDTH = 40
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input samples
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // setpoint[15:0], measured_angle[31:16]
    // results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata    // left_speed[14:0], right_speed[29:15],
                                              // control_effort[53:30], zero[55:54]
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    // register bank
    pdws_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer
    pdws_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // arithmetic
    pdws_datapath #(
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .cmd     (cmd),
        .status  (status),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule
